// ===== src/mlsc_pkg.sv =====
// Package for the motion light spotlight controller.
// Holds the payload, configuration and result types and the code constants.
// No dependencies.
`default_nettype none

package mlsc_pkg;

   localparam int unsigned LIGHT_W   = 12;
   localparam int unsigned MV_W      = 13;
   localparam int unsigned SECONDS_W = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      PH_OFF       = 2'd0,
      PH_DETECTING = 2'd1,
      PH_DETECTED  = 2'd2,
      PH_CLEARING  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      WK_LEAVE = 2'd0,
      WK_SET   = 2'd1,
      WK_STOP  = 2'd2
   } wake_cmd_type;

   typedef enum logic [1:0] {
      LED_OFF      = 2'd0,
      LED_NIGHT    = 2'd1,
      LED_TWILIGHT = 2'd2
   } led_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NIGHT_THRESHOLD       = 3'd0,
      CSR_BRIGHT_THRESHOLD      = 3'd1,
      CSR_BATTERY_EMPTY_MV      = 3'd2,
      CSR_BATTERY_LOW_MV        = 3'd3,
      CSR_MOTION_HOLD_SECONDS   = 3'd4,
      CSR_IDLE_RECHECK_SECONDS  = 3'd5,
      CSR_LIGHT_RECHECK_SECONDS = 3'd6
   } csr_index_type;

   localparam logic [LIGHT_W-1:0]   NIGHT_THRESHOLD_RST       = 12'd100;
   localparam logic [LIGHT_W-1:0]   BRIGHT_THRESHOLD_RST      = 12'd350;
   localparam logic [MV_W-1:0]      BATTERY_EMPTY_MV_RST      = 13'd3400;
   localparam logic [MV_W-1:0]      BATTERY_LOW_MV_RST        = 13'd3481;
   localparam logic [SECONDS_W-1:0] MOTION_HOLD_SECONDS_RST   = 16'd90;
   localparam logic [SECONDS_W-1:0] IDLE_RECHECK_SECONDS_RST  = 16'd60;
   localparam logic [SECONDS_W-1:0] LIGHT_RECHECK_SECONDS_RST = 16'd10;

   typedef struct packed {
      logic [LIGHT_W-1:0]   night_threshold;
      logic [LIGHT_W-1:0]   bright_threshold;
      logic [MV_W-1:0]      battery_empty_mv;
      logic [MV_W-1:0]      battery_low_mv;
      logic [SECONDS_W-1:0] motion_hold_seconds;
      logic [SECONDS_W-1:0] idle_recheck_seconds;
      logic [SECONDS_W-1:0] light_recheck_seconds;
   } cfg_type;

   typedef struct packed {
      logic               radar_switch;
      logic               light_switch;
      logic [LIGHT_W-1:0] light_level;
      logic [MV_W-1:0]    battery_mv;
      logic               charger_present;
      logic               charge_done;
      logic               motion_event;
      logic               timer_event;
   } req_type;

   typedef struct packed {
      logic                 radar_power;
      led_mode_type         led_mode;
      logic                 low_battery_alert;
      logic                 charging_shown;
      wake_cmd_type         wake_command;
      logic [SECONDS_W-1:0] wake_seconds;
      phase_type            motion_phase;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/mlsc_if.sv =====
// Channel interfaces for the wake-up requests and the controller results.
// Depends on mlsc_pkg for field widths.
`default_nettype none

interface mlsc_req_if
   import mlsc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               radar_switch;
   logic               light_switch;
   logic [LIGHT_W-1:0] light_level;
   logic [MV_W-1:0]    battery_mv;
   logic               charger_present;
   logic               charge_done;
   logic               motion_event;
   logic               timer_event;

   modport source (
      output valid, radar_switch, light_switch, light_level, battery_mv,
             charger_present, charge_done, motion_event, timer_event,
      input  ready
   );
   modport sink (
      input  valid, radar_switch, light_switch, light_level, battery_mv,
             charger_present, charge_done, motion_event, timer_event,
      output ready
   );
endinterface

interface mlsc_rsp_if
   import mlsc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 radar_power;
   logic [1:0]           led_mode;
   logic                 low_battery_alert;
   logic                 charging_shown;
   logic [1:0]           wake_command;
   logic [SECONDS_W-1:0] wake_seconds;
   logic [1:0]           motion_phase;

   modport source (
      output valid, radar_power, led_mode, low_battery_alert, charging_shown,
             wake_command, wake_seconds, motion_phase,
      input  ready
   );
   modport sink (
      input  valid, radar_power, led_mode, low_battery_alert, charging_shown,
             wake_command, wake_seconds, motion_phase,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/mlsc_cfg_regs.sv =====
// Configuration register file for the spotlight controller.
// Depends on mlsc_pkg for the register index codes and reset values.
`default_nettype none

module mlsc_cfg_regs
   import mlsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_NIGHT_THRESHOLD:       cfg_in.night_threshold = wr_data[LIGHT_W-1:0];
            CSR_BRIGHT_THRESHOLD:      cfg_in.bright_threshold = wr_data[LIGHT_W-1:0];
            CSR_BATTERY_EMPTY_MV:      cfg_in.battery_empty_mv = wr_data[MV_W-1:0];
            CSR_BATTERY_LOW_MV:        cfg_in.battery_low_mv = wr_data[MV_W-1:0];
            CSR_MOTION_HOLD_SECONDS:   cfg_in.motion_hold_seconds = wr_data;
            CSR_IDLE_RECHECK_SECONDS:  cfg_in.idle_recheck_seconds = wr_data;
            CSR_LIGHT_RECHECK_SECONDS: cfg_in.light_recheck_seconds = wr_data;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.night_threshold       <= NIGHT_THRESHOLD_RST;
         cfg_ff.bright_threshold      <= BRIGHT_THRESHOLD_RST;
         cfg_ff.battery_empty_mv      <= BATTERY_EMPTY_MV_RST;
         cfg_ff.battery_low_mv        <= BATTERY_LOW_MV_RST;
         cfg_ff.motion_hold_seconds   <= MOTION_HOLD_SECONDS_RST;
         cfg_ff.idle_recheck_seconds  <= IDLE_RECHECK_SECONDS_RST;
         cfg_ff.light_recheck_seconds <= LIGHT_RECHECK_SECONDS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/mlsc_core.sv =====
// Controller state and the per-wake-up decision logic.
// Depends on mlsc_pkg for the phase, LED and wake command codes.
`default_nettype none

module mlsc_core
   import mlsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire cfg_type cfg,
   input  wire req_type req,
   output rsp_type      rsp
);

   phase_type    phase_ff, phase_in;
   led_mode_type led_ff, led_in;
   logic         depleted_ff, depleted_in;
   logic         low_ff, low_in;
   logic         ignore_ff, ignore_in;
   logic         radar_ff, radar_in;

   logic         motion;
   logic         dark;
   logic         alert;
   logic         charging;
   wake_cmd_type wcmd;
   logic [SECONDS_W-1:0] wsec;

   assign dark = req.light_level < cfg.night_threshold;

   always_comb begin
      phase_in    = phase_ff;
      led_in      = led_ff;
      ignore_in   = ignore_ff;
      radar_in    = radar_ff;
      depleted_in = depleted_ff | (req.battery_mv < cfg.battery_empty_mv);
      low_in      = low_ff | (req.battery_mv < cfg.battery_low_mv);
      motion      = req.motion_event;
      alert       = 1'b0;
      charging    = 1'b0;
      wcmd        = WK_LEAVE;
      wsec        = '0;

      if (depleted_in || req.charger_present) begin
         phase_in = PH_OFF;
         radar_in = 1'b0;
         led_in   = LED_OFF;
      end

      // depleted without charger: everything stays off, timer left alone
      if (!(depleted_in && !req.charger_present)) begin
         if (req.charger_present || req.charge_done) begin
            charging    = 1'b1;
            depleted_in = 1'b0;
            low_in      = 1'b0;
         end
         if (!req.radar_switch) begin
            radar_in = 1'b0;
            phase_in = PH_OFF;
         end
         // discard the first radar event after power-up
         if (motion && ignore_in) begin
            motion    = 1'b0;
            ignore_in = 1'b0;
         end

         if (!req.radar_switch && !req.light_switch) begin
            led_in = LED_OFF;
            wcmd   = WK_SET;
            wsec   = cfg.idle_recheck_seconds;
         end else if (!req.radar_switch) begin
            // dead band between the thresholds keeps the LED state
            if (req.light_level >= cfg.bright_threshold) begin
               led_in = LED_OFF;
            end else if (dark) begin
               alert  = low_in;
               led_in = LED_NIGHT;
            end
            wcmd = WK_SET;
            wsec = cfg.light_recheck_seconds;
         end else if (req.light_switch && !dark) begin
            if (phase_in != PH_OFF) begin
               phase_in = PH_OFF;
               led_in   = LED_OFF;
               radar_in = 1'b0;
            end
            wcmd = WK_SET;
            wsec = cfg.idle_recheck_seconds;
         end else begin
            case (phase_in)
               PH_OFF: begin
                  phase_in  = PH_DETECTING;
                  radar_in  = 1'b1;
                  ignore_in = 1'b1;
                  wcmd      = WK_STOP;
               end
               PH_DETECTING: begin
                  if (motion) begin
                     phase_in = PH_DETECTED;
                     radar_in = 1'b0;
                     wcmd     = WK_SET;
                     wsec     = cfg.motion_hold_seconds;
                  end
               end
               PH_DETECTED: begin
                  if (req.timer_event) begin
                     phase_in  = PH_CLEARING;
                     radar_in  = 1'b1;
                     ignore_in = 1'b1;
                     wcmd      = WK_SET;
                     wsec      = cfg.motion_hold_seconds;
                  end
               end
               default: begin
                  if (motion) begin
                     phase_in = PH_DETECTED;
                     radar_in = 1'b0;
                     wcmd     = WK_SET;
                     wsec     = cfg.motion_hold_seconds;
                  end else if (req.timer_event) begin
                     phase_in = PH_DETECTING;
                     wcmd     = WK_STOP;
                  end
               end
            endcase
            if (phase_in == PH_DETECTED || phase_in == PH_CLEARING) begin
               alert  = low_in;
               led_in = dark ? LED_NIGHT : LED_TWILIGHT;
            end else begin
               led_in = LED_OFF;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OFF;
         led_ff      <= LED_OFF;
         depleted_ff <= 1'b0;
         low_ff      <= 1'b0;
         ignore_ff   <= 1'b0;
         radar_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         led_ff      <= led_in;
         depleted_ff <= depleted_in;
         low_ff      <= low_in;
         ignore_ff   <= ignore_in;
         radar_ff    <= radar_in;
      end
   end

   always_comb begin
      rsp.radar_power       = radar_in;
      rsp.led_mode          = led_in;
      rsp.low_battery_alert = alert;
      rsp.charging_shown    = charging;
      rsp.wake_command      = wcmd;
      rsp.wake_seconds      = wsec;
      rsp.motion_phase      = phase_in;
   end

endmodule

`default_nettype wire

// ===== src/motion_light_spotlight_controller.sv =====
// A wake-up accepted into the input register passes through the single decision
// step into the result register once that slot is free or being taken. One
// wake-up per cycle while the result side keeps ready high; a stall holds both.
// Reset: synchronous, active high; clears all controller state to off and
// loads the configuration registers with their default values.
`default_nettype none

module motion_light_spotlight_controller
   import mlsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mlsc_req_if.sink                   req_chan,
   mlsc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    req_transfer;

   mlsc_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   mlsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   // move the held item into the result register when that slot frees up
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_transfer   = req_chan.valid && req_chan.ready;

   always_comb begin
      req_in.radar_switch    = req_chan.radar_switch;
      req_in.light_switch    = req_chan.light_switch;
      req_in.light_level     = req_chan.light_level;
      req_in.battery_mv      = req_chan.battery_mv;
      req_in.charger_present = req_chan.charger_present;
      req_in.charge_done     = req_chan.charge_done;
      req_in.motion_event    = req_chan.motion_event;
      req_in.timer_event     = req_chan.timer_event;
   end

   always_comb begin
      req_valid_in = req_transfer ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.radar_power       = rsp_ff.radar_power;
   assign rsp_chan.led_mode          = rsp_ff.led_mode;
   assign rsp_chan.low_battery_alert = rsp_ff.low_battery_alert;
   assign rsp_chan.charging_shown    = rsp_ff.charging_shown;
   assign rsp_chan.wake_command      = rsp_ff.wake_command;
   assign rsp_chan.wake_seconds      = rsp_ff.wake_seconds;
   assign rsp_chan.motion_phase      = rsp_ff.motion_phase;

`ifndef SYNTHESIS
   a_seconds_only_when_set: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.wake_command != WK_SET) |-> rsp_chan.wake_seconds == '0)
      else $error("wake_seconds nonzero without a set command");

   a_radar_off_when_detected: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.motion_phase == PH_DETECTED) |-> !rsp_chan.radar_power)
      else $error("radar powered in the detected phase");

   a_radar_on_when_watching: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && ((rsp_chan.motion_phase == PH_DETECTING) ||
                         (rsp_chan.motion_phase == PH_CLEARING)) |-> rsp_chan.radar_power)
      else $error("radar off while watching for motion");

   a_alert_needs_leds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.low_battery_alert |-> rsp_chan.led_mode != LED_OFF)
      else $error("low battery alert with LEDs off");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/motion_light_spotlight_controller_test.sv =====
// Self-checking bench for motion_light_spotlight_controller.
// Drives wake-ups over mlsc_req_if, checks results on mlsc_rsp_if against a
// local predictor. Depends on mlsc_pkg, mlsc_if and the controller RTL.
module motion_light_spotlight_controller_test;
   import mlsc_pkg::*;

   typedef struct {
      req_type wake;
      bit      settle;
   } pending_wakeup_type;

   typedef enum {EPI_MOTION, EPI_LIGHT_ONLY, EPI_NOISE} episode_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mlsc_req_if req_chan();
   mlsc_rsp_if rsp_chan();

   motion_light_spotlight_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and configuration shadow
   cfg_type      csr_shadow;
   phase_type    phase_now;
   led_mode_type led_now;
   logic         depleted;
   logic         low_batt;
   logic         skip_next_motion;
   logic         radar_on;

   pending_wakeup_type wakeups_to_send[$];
   rsp_type            expected_outcomes[$];

   int  sender_idle_pct;
   int  receiver_stall_pct;
   bit  req_sent;
   int  wakeups_accepted;
   int  outcomes_seen;
   int  mismatches;
   int  config_sets;

   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   function automatic rsp_type evaluate_wakeup(req_type w);
      rsp_type              o;
      logic                 motion;
      logic                 alert;
      logic                 charging;
      logic                 dark;
      wake_cmd_type         cmd;
      logic [SECONDS_W-1:0] secs;
      motion   = w.motion_event;
      alert    = 1'b0;
      charging = 1'b0;
      cmd      = WK_LEAVE;
      secs     = '0;
      dark     = w.light_level < csr_shadow.night_threshold;
      if (w.battery_mv < csr_shadow.battery_empty_mv) depleted = 1'b1;
      if (w.battery_mv < csr_shadow.battery_low_mv) low_batt = 1'b1;
      if (depleted || w.charger_present) begin
         phase_now = PH_OFF;
         radar_on  = 1'b0;
         led_now   = LED_OFF;
      end
      // depleted without charger: everything stays off, timer untouched
      if (!depleted || w.charger_present) begin
         if (w.charger_present || w.charge_done) begin
            charging = 1'b1;
            depleted = 1'b0;
            low_batt = 1'b0;
         end
         if (!w.radar_switch) begin
            radar_on  = 1'b0;
            phase_now = PH_OFF;
         end
         // drop the first radar event after power-up
         if (motion && skip_next_motion) begin
            motion           = 1'b0;
            skip_next_motion = 1'b0;
         end
         if (!w.radar_switch && !w.light_switch) begin
            led_now = LED_OFF;
            cmd     = WK_SET;
            secs    = csr_shadow.idle_recheck_seconds;
         end else if (!w.radar_switch) begin
            if (w.light_level >= csr_shadow.bright_threshold) begin
               led_now = LED_OFF;
            end else if (dark) begin
               alert   = low_batt;
               led_now = LED_NIGHT;
            end
            cmd  = WK_SET;
            secs = csr_shadow.light_recheck_seconds;
         end else if (w.light_switch && !dark) begin
            if (phase_now != PH_OFF) begin
               phase_now = PH_OFF;
               led_now   = LED_OFF;
               radar_on  = 1'b0;
            end
            cmd  = WK_SET;
            secs = csr_shadow.idle_recheck_seconds;
         end else begin
            case (phase_now)
               PH_OFF: begin
                  phase_now        = PH_DETECTING;
                  radar_on         = 1'b1;
                  skip_next_motion = 1'b1;
                  cmd              = WK_STOP;
               end
               PH_DETECTING: begin
                  if (motion) begin
                     phase_now = PH_DETECTED;
                     radar_on  = 1'b0;
                     cmd       = WK_SET;
                     secs      = csr_shadow.motion_hold_seconds;
                  end
               end
               PH_DETECTED: begin
                  if (w.timer_event) begin
                     phase_now        = PH_CLEARING;
                     radar_on         = 1'b1;
                     skip_next_motion = 1'b1;
                     cmd              = WK_SET;
                     secs             = csr_shadow.motion_hold_seconds;
                  end
               end
               default: begin
                  if (motion) begin
                     phase_now = PH_DETECTED;
                     radar_on  = 1'b0;
                     cmd       = WK_SET;
                     secs      = csr_shadow.motion_hold_seconds;
                  end else if (w.timer_event) begin
                     phase_now = PH_DETECTING;
                     cmd       = WK_STOP;
                  end
               end
            endcase
            if (phase_now == PH_DETECTED || phase_now == PH_CLEARING) begin
               alert = low_batt;
               if (dark) begin
                  led_now = LED_NIGHT;
               end else begin
                  led_now = LED_TWILIGHT;
               end
            end else begin
               led_now = LED_OFF;
            end
         end
      end
      o.radar_power       = radar_on;
      o.led_mode          = led_now;
      o.low_battery_alert = alert;
      o.charging_shown    = charging;
      o.wake_command      = cmd;
      o.wake_seconds      = (cmd == WK_SET) ? secs : '0;
      o.motion_phase      = phase_now;
      return o;
   endfunction

   function automatic req_type wake(int rs, int ls, int unsigned light, int unsigned mv,
                                    int chg, int done, int mot, int tmr);
      req_type w;
      w.radar_switch    = rs[0];
      w.light_switch    = ls[0];
      w.light_level     = light[LIGHT_W-1:0];
      w.battery_mv      = mv[MV_W-1:0];
      w.charger_present = chg[0];
      w.charge_done     = done[0];
      w.motion_event    = mot[0];
      w.timer_event     = tmr[0];
      return w;
   endfunction

   function automatic req_type random_wakeup(episode_kind_type kind);
      req_type     w;
      logic [31:0] r;
      int unsigned floor_mv;
      int unsigned night;
      int unsigned bright;
      r        = $urandom();
      w        = r[$bits(req_type)-1:0];
      night    = 32'(csr_shadow.night_threshold);
      bright   = 32'(csr_shadow.bright_threshold);
      floor_mv = 32'(csr_shadow.battery_empty_mv);
      if (csr_shadow.battery_low_mv > floor_mv) floor_mv = 32'(csr_shadow.battery_low_mv);
      if (kind == EPI_NOISE) return w;
      // mostly a healthy battery so the sequences get past the depleted state
      if ($urandom_range(11) != 0) w.battery_mv = MV_W'($urandom_range(8191, floor_mv));
      w.charger_present = ($urandom_range(24) == 0);
      w.charge_done     = ($urandom_range(24) == 0);
      if (kind == EPI_MOTION) begin
         w.radar_switch = 1'b1;
         if (night != 0 && $urandom_range(9) < 8)
            w.light_level = LIGHT_W'($urandom_range(night - 1, 0));
      end else begin
         w.radar_switch = 1'b0;
         w.light_switch = ($urandom_range(7) != 0);
         case ($urandom_range(2))
            0: if (night != 0) w.light_level = LIGHT_W'($urandom_range(night - 1, 0));
            1: if (night < bright) w.light_level = LIGHT_W'($urandom_range(bright - 1, night));
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result %0d field %s expected %0d got %0d",
                     $realtime, outcomes_seen, name, want, got);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_NIGHT_THRESHOLD:       csr_shadow.night_threshold       = value[LIGHT_W-1:0];
         CSR_BRIGHT_THRESHOLD:      csr_shadow.bright_threshold      = value[LIGHT_W-1:0];
         CSR_BATTERY_EMPTY_MV:      csr_shadow.battery_empty_mv      = value[MV_W-1:0];
         CSR_BATTERY_LOW_MV:        csr_shadow.battery_low_mv        = value[MV_W-1:0];
         CSR_MOTION_HOLD_SECONDS:   csr_shadow.motion_hold_seconds   = value;
         CSR_IDLE_RECHECK_SECONDS:  csr_shadow.idle_recheck_seconds  = value;
         CSR_LIGHT_RECHECK_SECONDS: csr_shadow.light_recheck_seconds = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_settings(cfg_type c);
      write_csr(CSR_NIGHT_THRESHOLD, CSR_DATA_W'(c.night_threshold));
      write_csr(CSR_BRIGHT_THRESHOLD, CSR_DATA_W'(c.bright_threshold));
      write_csr(CSR_BATTERY_EMPTY_MV, CSR_DATA_W'(c.battery_empty_mv));
      write_csr(CSR_BATTERY_LOW_MV, CSR_DATA_W'(c.battery_low_mv));
      write_csr(CSR_MOTION_HOLD_SECONDS, c.motion_hold_seconds);
      write_csr(CSR_IDLE_RECHECK_SECONDS, c.idle_recheck_seconds);
      write_csr(CSR_LIGHT_RECHECK_SECONDS, c.light_recheck_seconds);
      config_sets++;
   endtask

   function automatic cfg_type phase_settings(int p);
      cfg_type c;
      c = '{NIGHT_THRESHOLD_RST, BRIGHT_THRESHOLD_RST, BATTERY_EMPTY_MV_RST,
            BATTERY_LOW_MV_RST, MOTION_HOLD_SECONDS_RST, IDLE_RECHECK_SECONDS_RST,
            LIGHT_RECHECK_SECONDS_RST};
      case (p)
         0, 5: ;
         // thresholds inverted, low battery below 8191 mV, zero idle period
         1: c = '{12'd4095, 12'd0, 13'd0, 13'd8191, 16'd65535, 16'd0, 16'd1};
         // nothing is ever dark, zero light-only period
         2: c = '{12'd0, 12'd4095, 13'd8191, 13'd0, 16'd1, 16'd65535, 16'd0};
         default: begin
            c.night_threshold       = LIGHT_W'($urandom_range(600, 20));
            c.bright_threshold      = LIGHT_W'(c.night_threshold + $urandom_range(800));
            c.battery_empty_mv      = MV_W'($urandom_range(4000, 2800));
            c.battery_low_mv        = MV_W'(c.battery_empty_mv + $urandom_range(300));
            c.motion_hold_seconds   = SECONDS_W'($urandom_range(65535, 1));
            c.idle_recheck_seconds  = SECONDS_W'($urandom_range(65535, 1));
            c.light_recheck_seconds = SECONDS_W'($urandom_range(65535, 1));
         end
      endcase
      return c;
   endfunction

   task automatic queue_wakeup(req_type w, int settle);
      pending_wakeup_type pw;
      pw.wake   = w;
      pw.settle = settle[0];
      wakeups_to_send.push_back(pw);
   endtask

   // runs with the default thresholds: dark below 100, bright at 350,
   // empty below 3400 mV, low below 3481 mV
   task automatic queue_directed();
      queue_wakeup(wake(0, 0, 0, 0, 0, 0, 0, 0), 0);
      queue_wakeup(wake(1, 1, 4095, 8191, 0, 1, 1, 1), 0);
      queue_wakeup(wake(0, 1, 0, 8191, 1, 0, 0, 0), 0);
      queue_wakeup(wake(0, 1, 50, 3450, 0, 0, 0, 0), 0);
      queue_wakeup(wake(0, 1, 200, 8191, 0, 0, 0, 0), 0);
      queue_wakeup(wake(0, 1, 4095, 8191, 0, 0, 0, 0), 0);
      queue_wakeup(wake(0, 1, 349, 8191, 0, 0, 0, 0), 0);
      queue_wakeup(wake(0, 1, 99, 8191, 0, 0, 0, 0), 0);
      queue_wakeup(wake(0, 0, 0, 8191, 0, 0, 1, 1), 0);
      queue_wakeup(wake(1, 0, 4095, 8191, 0, 0, 0, 0), 0);
      queue_wakeup(wake(1, 0, 4095, 8191, 0, 0, 1, 0), 0);
      queue_wakeup(wake(1, 0, 4095, 8191, 0, 0, 1, 0), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 0, 0, 0, 1), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 0, 0, 1, 0), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 0, 0, 0, 1), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 0, 0, 1, 0), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 0, 0, 0, 1), 0);
      queue_wakeup(wake(1, 1, 0, 8191, 1, 0, 0, 0), 0);
      queue_wakeup(wake(1, 1, 100, 8191, 0, 0, 1, 1), 0);
      queue_wakeup(wake(1, 1, 4095, 8191, 0, 0, 1, 1), 0);
      queue_wakeup(wake(1, 1, 99, 3399, 0, 0, 0, 0), 0);
      queue_wakeup(wake(1, 1, 99, 3400, 0, 1, 0, 0), 0);
      queue_wakeup(wake(1, 1, 99, 3400, 1, 1, 0, 0), 0);
      queue_wakeup(wake(1, 1, 99, 8191, 0, 0, 1, 1), 0);
      queue_wakeup(wake(1, 1, 99, 8191, 0, 0, 1, 0), 0);
   endtask

   task automatic queue_random(int count);
      int               queued;
      int               len;
      int               pick;
      episode_kind_type kind;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(9);
         if (pick < 6) kind = EPI_MOTION;
         else if (pick < 8) kind = EPI_LIGHT_ONLY;
         else kind = EPI_NOISE;
         len = $urandom_range(12, 3);
         repeat (len) begin
            // first one of the phase holds until the pipeline has drained
            queue_wakeup(random_wakeup(kind), int'(queued == 0 || $urandom_range(49) == 0));
            queued++;
         end
      end
   endtask

   task automatic wait_until_idle();
      while (wakeups_to_send.size() != 0 || req_chan.valid || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock) begin : req_driver
      pending_wakeup_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         // hold the current item until its transfer
         if (!req_chan.valid || req_sent) begin
            req_sent = 1'b0;
            if (wakeups_to_send.size() != 0
                && !(wakeups_to_send[0].settle && expected_outcomes.size() != 0)
                && $urandom_range(99) >= sender_idle_pct) begin
               nxt = wakeups_to_send.pop_front();
               req_chan.radar_switch    <= nxt.wake.radar_switch;
               req_chan.light_switch    <= nxt.wake.light_switch;
               req_chan.light_level     <= nxt.wake.light_level;
               req_chan.battery_mv      <= nxt.wake.battery_mv;
               req_chan.charger_present <= nxt.wake.charger_present;
               req_chan.charge_done     <= nxt.wake.charge_done;
               req_chan.motion_event    <= nxt.wake.motion_event;
               req_chan.timer_event     <= nxt.wake.timer_event;
               req_chan.valid           <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      req_type w;
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            w = {req_chan.radar_switch, req_chan.light_switch, req_chan.light_level,
                 req_chan.battery_mv, req_chan.charger_present, req_chan.charge_done,
                 req_chan.motion_event, req_chan.timer_event};
            expected_outcomes.push_back(evaluate_wakeup(w));
            wakeups_accepted++;
            req_sent = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.radar_power, rsp_chan.led_mode, rsp_chan.low_battery_alert,
                   rsp_chan.charging_shown, rsp_chan.wake_command, rsp_chan.wake_seconds,
                   rsp_chan.motion_phase};
            outcomes_seen++;
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %0d arrived with nothing expected",
                           $realtime, outcomes_seen);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("radar_power", 16'(want.radar_power), 16'(got.radar_power));
               check_field("led_mode", 16'(want.led_mode), 16'(got.led_mode));
               check_field("low_battery_alert", 16'(want.low_battery_alert),
                           16'(got.low_battery_alert));
               check_field("charging_shown", 16'(want.charging_shown),
                           16'(got.charging_shown));
               check_field("wake_command", 16'(want.wake_command), 16'(got.wake_command));
               check_field("wake_seconds", want.wake_seconds, got.wake_seconds);
               check_field("motion_phase", 16'(want.motion_phase), 16'(got.motion_phase));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d wake-ups accepted, %0d results seen",
               wakeups_accepted, outcomes_seen);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_index                = CSR_NIGHT_THRESHOLD;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.radar_switch    = 1'b0;
      req_chan.light_switch    = 1'b0;
      req_chan.light_level     = '0;
      req_chan.battery_mv      = '0;
      req_chan.charger_present = 1'b0;
      req_chan.charge_done     = 1'b0;
      req_chan.motion_event    = 1'b0;
      req_chan.timer_event     = 1'b0;
      rsp_chan.ready           = 1'b0;
      req_sent                 = 1'b0;
      sender_idle_pct          = 0;
      receiver_stall_pct       = 0;
      wakeups_accepted         = 0;
      outcomes_seen            = 0;
      mismatches               = 0;
      config_sets              = 0;
      csr_shadow = '{NIGHT_THRESHOLD_RST, BRIGHT_THRESHOLD_RST, BATTERY_EMPTY_MV_RST,
                     BATTERY_LOW_MV_RST, MOTION_HOLD_SECONDS_RST, IDLE_RECHECK_SECONDS_RST,
                     LIGHT_RECHECK_SECONDS_RST};
      phase_now        = PH_OFF;
      led_now          = LED_OFF;
      depleted         = 1'b0;
      low_batt         = 1'b0;
      skip_next_motion = 1'b0;
      radar_on         = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         wait_until_idle();
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
            default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
         endcase
         program_settings(phase_settings(p));
         if (p == 0) queue_directed();
         queue_random(188);
      end
      wait_until_idle();
      repeat (4) @(negedge clock);

      $display("Ran %0d wake-ups through %0d register settings and checked %0d results.",
               wakeups_accepted, config_sets, outcomes_seen);
      $display("Field mismatches or stray results: %0d", mismatches);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mlsc_pkg.sv
src/mlsc_if.sv
src/mlsc_cfg_regs.sv
src/mlsc_core.sv
src/motion_light_spotlight_controller.sv
tb/sv/motion_light_spotlight_controller_test.sv
